@@ src/hcs_pkg.sv @@
package hcs_pkg;

  localparam int MaxPartials = 16;
  localparam int PartIdxW = 4;
  localparam int CordicSteps = 20;
  localparam int StepW = 5;

  localparam logic [0:0] OpLoad    = 1'b0;
  localparam logic [0:0] OpCompute = 1'b1;

  localparam logic [2:0] RegHalfChirp   = 3'd0;
  localparam logic [2:0] RegBaseFreq    = 3'd1;
  localparam logic [2:0] RegGlobalAmp   = 3'd2;
  localparam logic [2:0] RegGlobalPhase = 3'd3;
  localparam logic [2:0] RegActive      = 3'd4;

  localparam logic signed [33:0] CordicX0 = 34'sd652032874;

  // Per-step rotation angle, turns at scale 2^-32.
  function automatic logic [31:0] cordic_angle(input logic [StepW-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Data handed from one cell to the next in the CORDIC row.
  typedef struct packed {
    logic               vld;
    logic               neg;
    logic               last;
    logic signed [15:0] amp;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } cord_t;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StBase  = 4'b0010,
    StIssue = 4'b0100,
    StDrain = 4'b1000
  } state_t;

endpackage

@@ src/hcs_cell.sv @@
module hcs_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic [4:0]          step,
  input  hcs_pkg::cord_t      din,
  output hcs_pkg::cord_t      dout
);
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic [31:0] ang;
  hcs_pkg::cord_t nxt;

  assign dx  = din.y >>> step;
  assign dy  = din.x >>> step;
  assign ang = hcs_pkg::cordic_angle(step);

  always_comb begin
    nxt = din;
    if (!din.z[32]) begin
      nxt.x = din.x - dx;
      nxt.y = din.y + dy;
      nxt.z = din.z - $signed({1'b0, ang});
    end else begin
      nxt.x = din.x + dx;
      nxt.y = din.y - dy;
      nxt.z = din.z + $signed({1'b0, ang});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.neg  <= nxt.neg;
    dout.last <= nxt.last;
    dout.amp  <= nxt.amp;
    dout.x    <= nxt.x;
    dout.y    <= nxt.y;
    dout.z    <= nxt.z;
  end
endmodule

@@ src/hcs_cordic.sv @@
module hcs_cordic (
  input  logic               clk,
  input  logic               rst,
  input  hcs_pkg::cord_t     din,
  output hcs_pkg::cord_t     dout
);
  hcs_pkg::cord_t link [hcs_pkg::CordicSteps+1];

  assign link[0] = din;

  for (genvar g = 0; g < hcs_pkg::CordicSteps; g++) begin : g_cell
    hcs_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .step (5'(g)),
      .din  (link[g]),
      .dout (link[g+1])
    );
  end

  assign dout = link[hcs_pkg::CordicSteps];
endmodule

@@ src/harmonic_chirp_synthesizer.sv @@
// Harmonic chirp synthesizer.
// The slave channel (s_axis_*) carries load and compute items; tuser is the
// opcode. A load writes one entry of the partial table and gives no result.
// A compute item takes a sample index and a window value and gives one
// result item on the master channel (m_axis_*): the windowed sum of the
// active partials (at least one), signed Q5.18, with the sample index echoed.
// Configuration registers are written through cfg_we/cfg_addr/cfg_data, by
// the user only while the block is idle, which the block does not enforce;
// writes to unknown indexes are dropped. A compute, once accepted, runs the
// base-phase arithmetic in two multiply steps, then issues one partial per
// cycle through a partial-phase register into a row of twenty CORDIC cells,
// a cosine register, the accumulator, and the rounding and window registers,
// and then raises m_axis_tvalid. The single CORDIC row and the accumulator
// serve all partials; one compute is in flight at a time, so a new compute is
// taken only after the previous result has left the output register.
// The result waits in an output register; while the receiver stalls, the
// block holds it and takes no new compute item, but a load is still taken.
// Reset (synchronous, active high) restores the configuration registers and the partial
// table to their defaults: factor j+1, amplitude and phase zero.
module harmonic_chirp_synthesizer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, lowest bit up: partial_index[3:0], harmonic_factor[27:4],
  // partial_amp[43:28], partial_phase[75:44], sample_index[91:76],
  // window_value[107:92]
  input  logic [111:0] s_axis_tdata,
  // tuser: opcode
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata, lowest bit up: sample_out[23:0], sample_index_out[39:24]
  output logic [39:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [47:0]  cfg_data
);
  logic [47:0] half_chirp;
  logic [31:0] base_freq;
  logic [15:0] global_amp;
  logic [31:0] global_phase;
  logic [4:0]  active_partials;

  logic [23:0] factor_table [hcs_pkg::MaxPartials];
  logic [15:0] amp_table    [hcs_pkg::MaxPartials];
  logic [31:0] phase_table  [hcs_pkg::MaxPartials];

  hcs_pkg::state_t state;
  logic [15:0] t_reg;
  logic [15:0] w_reg;
  logic [47:0] acc_b;
  logic [47:0] b;
  logic [1:0]  bcnt;
  logic [hcs_pkg::PartIdxW-1:0] pidx;
  logic [hcs_pkg::PartIdxW-1:0] plast;
  logic        out_vld;
  logic [23:0] out_sample;
  logic [15:0] out_t;

  logic [hcs_pkg::PartIdxW-1:0] in_idx;
  logic        acc_in;

  assign in_idx = s_axis_tdata[3:0];
  assign s_axis_tready = (state == hcs_pkg::StIdle) &&
                         (!out_vld || s_axis_tuser == hcs_pkg::OpLoad);
  assign acc_in = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_chirp <= '0;
      base_freq <= '0;
      global_amp <= '0;
      global_phase <= '0;
      active_partials <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        hcs_pkg::RegHalfChirp:   half_chirp <= cfg_data;
        hcs_pkg::RegBaseFreq:    base_freq <= cfg_data[31:0];
        hcs_pkg::RegGlobalAmp:   global_amp <= cfg_data[15:0];
        hcs_pkg::RegGlobalPhase: global_phase <= cfg_data[31:0];
        hcs_pkg::RegActive:      active_partials <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Table: sixteen entries kept in flops with reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < hcs_pkg::MaxPartials; j++) begin
        factor_table[j] <= 24'((j + 1) << 16);
        amp_table[j]    <= '0;
        phase_table[j]  <= '0;
      end
    end else if (acc_in && s_axis_tuser == hcs_pkg::OpLoad) begin
      factor_table[in_idx] <= s_axis_tdata[27:4];
      amp_table[in_idx]    <= s_axis_tdata[43:28];
      phase_table[in_idx]  <= s_axis_tdata[75:44];
    end
  end

  // Base phase over two multiply steps (each 48x16).
  logic [47:0] mul_b;
  assign mul_b = 48'(acc_b * {32'd0, t_reg});

  // Partial phase: factor*B, top 32 bits of the 64-bit product. Registered.
  logic [31:0] fb_top;
  logic [63:0] fb_full;
  logic [hcs_pkg::PartIdxW-1:0] pidx_r;
  logic        iss_vld;
  assign fb_full = 64'({40'd0, factor_table[pidx]} * {16'd0, b});

  hcs_pkg::cord_t c_in;
  hcs_pkg::cord_t c_out;
  logic [31:0] ph;
  logic [31:0] ph_f;
  logic        nfold;

  always_comb begin
    ph = fb_top + global_phase + phase_table[pidx_r];
    nfold = ph[31] ^ ph[30];
    ph_f = nfold ? ph + 32'h8000_0000 : ph;
    c_in.vld  = iss_vld;
    c_in.neg  = nfold;
    c_in.last = (pidx_r == plast);
    c_in.amp  = $signed(amp_table[pidx_r]);
    c_in.x    = hcs_pkg::CordicX0;
    c_in.y    = '0;
    c_in.z    = $signed({ph_f[31], ph_f});
  end

  hcs_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .din  (c_in),
    .dout (c_out)
  );

  // Cosine rounding then product with amplitudes.
  logic signed [33:0] xr;
  logic signed [17:0] cosv;
  assign xr = (c_out.x + 34'sd8192) >>> 14;
  assign cosv = c_out.neg ? -18'(xr) : 18'(xr);

  logic signed [33:0] ac_prod;
  logic signed [33:0] ac_r;
  logic signed [17:0] cos_r;
  logic               last_r;
  logic               vld_r;
  logic signed [52:0] sum;

  assign ac_prod = $signed({1'b0, global_amp}) * c_out.amp;

  logic signed [52:0] term;
  assign term = 53'(ac_r * cos_r);

  // Final stages.
  logic signed [52:0] s1;
  logic signed [40:0] s1n;
  logic signed [57:0] s2;
  logic signed [57:0] s2r;
  logic [1:0] fin;

  assign s1 = (sum + 53'sd4096) >>> 13;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcs_pkg::StIdle;
      out_vld <= 1'b0;
      vld_r <= 1'b0;
      iss_vld <= 1'b0;
      fin <= '0;
    end else begin
      vld_r <= c_out.vld;
      iss_vld <= (state == hcs_pkg::StIssue);
      if (m_axis_tvalid && m_axis_tready) out_vld <= 1'b0;
      case (state)
        hcs_pkg::StIdle: begin
          if (acc_in && s_axis_tuser == hcs_pkg::OpCompute) begin
            state <= hcs_pkg::StBase;
            bcnt <= '0;
          end
        end
        hcs_pkg::StBase: begin
          bcnt <= bcnt + 2'd1;
          if (bcnt == 2'd0) acc_b <= mul_b + {base_freq, 16'd0};
          else if (bcnt == 2'd1) begin
            b <= mul_b;
            state <= hcs_pkg::StIssue;
            pidx <= '0;
          end
        end
        hcs_pkg::StIssue: begin
          pidx <= pidx + 1'b1;
          if (pidx == plast) state <= hcs_pkg::StDrain;
        end
        hcs_pkg::StDrain: begin
          if (vld_r && last_r) fin <= 2'd1;
          if (fin == 2'd1) fin <= 2'd2;
          if (fin == 2'd2) fin <= 2'd3;
          if (fin == 2'd3) begin
            fin <= '0;
            out_vld <= 1'b1;
            state <= hcs_pkg::StIdle;
          end
        end
        default: state <= hcs_pkg::StIdle;
      endcase
    end
    // Datapath registers.
    if (acc_in && s_axis_tuser == hcs_pkg::OpCompute) begin
      t_reg <= s_axis_tdata[91:76];
      w_reg <= s_axis_tdata[107:92];
      acc_b <= half_chirp;
      sum <= '0;
      if (active_partials == 5'd0) plast <= '0;
      else if (active_partials > 5'(hcs_pkg::MaxPartials)) plast <= 4'(hcs_pkg::MaxPartials - 1);
      else plast <= 4'(active_partials - 5'd1);
    end
    fb_top <= fb_full[63:32];
    pidx_r <= pidx;
    cos_r <= cosv;
    ac_r <= ac_prod;
    last_r <= c_out.last;
    if (vld_r) sum <= sum + term;
    s1n <= 41'(s1);
    s2 <= 58'(s1n * $signed({1'b0, w_reg}));
    if (fin == 2'd3) begin
      if (s2r > 58'sd8388607) out_sample <= 24'h7FFFFF;
      else if (s2r < -58'sd8388608) out_sample <= 24'h800000;
      else out_sample <= 24'(s2r);
      out_t <= t_reg;
    end
  end

  assign s2r = (s2 + 58'sd2147483648) >>> 32;

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata = {out_t, out_sample};
endmodule

@@ src/hcs_checker.sv @@
module hcs_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [0:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [39:0]  m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_no_compute_while_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(s_axis_tready && s_axis_tuser == hcs_pkg::OpCompute))
    else $error("compute taken while result waits");
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == hcs_pkg::OpCompute
    |=> !m_axis_tvalid)
    else $error("result too early");
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("valid after reset");
endmodule

bind harmonic_chirp_synthesizer hcs_checker u_hcs_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tuser(s_axis_tuser), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
